/* hw/rtl/rct_pkg.sv */
`timescale 1ns / 1ps

package rct_pkg;

    // Fixed field widths
    localparam int CNT_W  = 32;
    localparam int TIME_W = 32;

    // Operation codes carried by the alarm channel
    localparam logic OP_CHECK = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Result codes
    typedef enum logic [2:0] {
        OUT_KNOWN     = 3'd0,
        OUT_NEW_FREE  = 3'd1,
        OUT_NEW_EVICT = 3'd2,
        OUT_REPLAY    = 3'd3,
        OUT_EMPTY     = 3'd4,
        OUT_CLEARED   = 3'd5
    } outcome_t;

    // Sequencer to scan unit
    typedef struct packed {
        logic init;   // restart the accumulators
        logic eval;   // read data of one slot is present this cycle
    } scan_ctrl_t;

    // Scan unit to sequencer
    typedef struct packed {
        logic hit;    // call sign found in a live slot
        logic free;   // at least one free slot seen
    } scan_flags_t;

endpackage

/* hw/rtl/replay_counter_table.sv */
`timescale 1ns / 1ps
// Channel  | Handshake                   | Payload
// alarm    | alarm_valid / alarm_ready   | operation, call_sign, counter, now_ms
// result   | result_valid / result_ready | accepted, outcome
//
// A check transaction scans every slot before the earliest next acceptance: the
// slot memory is read one entry per cycle and each entry passes through one shared
// compare/age unit, then a decide state makes the decision and writes back.
// Clear and empty-sign transactions skip the scan. Reset empties the table at once.
// A result waits in the output register; the alarm side is not ready until the
// pending transaction has delivered its result into that register.

module replay_counter_table #(
    parameter int SLOTS      = 16,
    parameter int SIGN_BYTES = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        alarm_valid,
    output logic                        alarm_ready,
    input  logic                        operation,
    input  logic [8*SIGN_BYTES-1:0]     call_sign,
    input  logic [rct_pkg::CNT_W-1:0]   counter,
    input  logic [rct_pkg::TIME_W-1:0]  now_ms,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic                        accepted,
    output logic [2:0]                  outcome
);

    localparam int SIGN_W = 8 * SIGN_BYTES;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic                       start;
    logic                       idle;
    logic                       out_free;
    logic                       res_valid;
    logic                       res_accepted;
    rct_pkg::outcome_t          res_outcome;

    logic                       rd_en;
    logic [IDX_W-1:0]           rd_addr;
    logic                       rd_valid;
    logic [SIGN_W-1:0]          rd_sign;
    logic [rct_pkg::CNT_W-1:0]  rd_cnt;
    logic [rct_pkg::TIME_W-1:0] rd_time;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    logic [SIGN_W-1:0]          wr_sign;
    logic [rct_pkg::CNT_W-1:0]  wr_cnt;
    logic [rct_pkg::TIME_W-1:0] wr_time;
    logic                       clear_all;

    rct_pkg::scan_ctrl_t        scan_ctrl;
    rct_pkg::scan_flags_t       flags;
    logic [IDX_W-1:0]           eval_idx;
    logic [SIGN_W-1:0]          key_sign;
    logic [rct_pkg::TIME_W-1:0] key_now;
    logic [IDX_W-1:0]           hit_idx;
    logic [rct_pkg::CNT_W-1:0]  hit_cnt;
    logic [IDX_W-1:0]           free_idx;
    logic [IDX_W-1:0]           old_idx;

    logic                       out_valid_reg;
    logic                       accepted_reg;
    logic [2:0]                 outcome_reg;

    assign alarm_ready = idle;
    assign start       = alarm_valid && idle;
    assign out_free    = !out_valid_reg || result_ready;

    rct_seq #(
        .SLOTS      (SLOTS),
        .SIGN_BYTES (SIGN_BYTES),
        .IDX_W      (IDX_W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .idle         (idle),
        .operation    (operation),
        .call_sign    (call_sign),
        .counter      (counter),
        .now_ms       (now_ms),
        .out_free     (out_free),
        .res_valid    (res_valid),
        .res_accepted (res_accepted),
        .res_outcome  (res_outcome),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_sign      (wr_sign),
        .wr_cnt       (wr_cnt),
        .wr_time      (wr_time),
        .clear_all    (clear_all),
        .scan_ctrl    (scan_ctrl),
        .eval_idx     (eval_idx),
        .key_sign     (key_sign),
        .key_now      (key_now),
        .flags        (flags),
        .hit_idx      (hit_idx),
        .hit_cnt      (hit_cnt),
        .free_idx     (free_idx),
        .old_idx      (old_idx)
    );

    rct_slot_mem #(
        .SLOTS  (SLOTS),
        .SIGN_W (SIGN_W),
        .IDX_W  (IDX_W)
    ) u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_valid  (rd_valid),
        .rd_sign   (rd_sign),
        .rd_cnt    (rd_cnt),
        .rd_time   (rd_time),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_sign   (wr_sign),
        .wr_cnt    (wr_cnt),
        .wr_time   (wr_time),
        .clear_all (clear_all)
    );

    rct_scan_unit #(
        .SIGN_W (SIGN_W),
        .IDX_W  (IDX_W)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (scan_ctrl),
        .eval_idx (eval_idx),
        .key_sign (key_sign),
        .now      (key_now),
        .rd_valid (rd_valid),
        .rd_sign  (rd_sign),
        .rd_cnt   (rd_cnt),
        .rd_time  (rd_time),
        .flags    (flags),
        .hit_idx  (hit_idx),
        .hit_cnt  (hit_cnt),
        .free_idx (free_idx),
        .old_idx  (old_idx)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            accepted_reg  <= 1'b0;
            outcome_reg   <= '0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
            accepted_reg  <= res_accepted;
            outcome_reg   <= res_outcome;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result_valid = out_valid_reg;
    assign accepted     = accepted_reg;
    assign outcome      = outcome_reg;

endmodule

/* hw/rtl/rct_slot_mem.sv */
`timescale 1ns / 1ps

module rct_slot_mem #(
    parameter int SLOTS  = 16,
    parameter int SIGN_W = 40,
    parameter int IDX_W  = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [IDX_W-1:0]          rd_addr,
    output logic                      rd_valid,
    output logic [SIGN_W-1:0]         rd_sign,
    output logic [rct_pkg::CNT_W-1:0] rd_cnt,
    output logic [rct_pkg::TIME_W-1:0] rd_time,
    input  logic                      wr_en,
    input  logic [IDX_W-1:0]          wr_addr,
    input  logic [SIGN_W-1:0]         wr_sign,
    input  logic [rct_pkg::CNT_W-1:0] wr_cnt,
    input  logic [rct_pkg::TIME_W-1:0] wr_time,
    input  logic                      clear_all
);

    localparam int ENTRY_W = SIGN_W + rct_pkg::CNT_W + rct_pkg::TIME_W;

    logic [ENTRY_W-1:0] mem [SLOTS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [SLOTS-1:0]   valid_reg;
    logic               rd_valid_reg;

    // Entry storage, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_sign, wr_cnt, wr_time};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Live flags: a slot that is not live reads as free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear_all)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_sign  = rd_data_reg[ENTRY_W-1 -: SIGN_W];
    assign rd_cnt   = rd_data_reg[rct_pkg::TIME_W +: rct_pkg::CNT_W];
    assign rd_time  = rd_data_reg[rct_pkg::TIME_W-1:0];

endmodule

/* hw/rtl/rct_scan_unit.sv */
`timescale 1ns / 1ps

module rct_scan_unit #(
    parameter int SIGN_W = 40,
    parameter int IDX_W  = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rct_pkg::scan_ctrl_t        ctrl,
    input  logic [IDX_W-1:0]           eval_idx,
    input  logic [SIGN_W-1:0]          key_sign,
    input  logic [rct_pkg::TIME_W-1:0] now,
    input  logic                       rd_valid,
    input  logic [SIGN_W-1:0]          rd_sign,
    input  logic [rct_pkg::CNT_W-1:0]  rd_cnt,
    input  logic [rct_pkg::TIME_W-1:0] rd_time,
    output rct_pkg::scan_flags_t       flags,
    output logic [IDX_W-1:0]           hit_idx,
    output logic [rct_pkg::CNT_W-1:0]  hit_cnt,
    output logic [IDX_W-1:0]           free_idx,
    output logic [IDX_W-1:0]           old_idx
);

    logic                       hit_reg;
    logic                       free_reg;
    logic [IDX_W-1:0]           hit_idx_reg;
    logic [rct_pkg::CNT_W-1:0]  hit_cnt_reg;
    logic [IDX_W-1:0]           free_idx_reg;
    logic [IDX_W-1:0]           old_idx_reg;
    logic [rct_pkg::TIME_W-1:0] old_age_reg;

    logic                       match;
    logic [rct_pkg::TIME_W-1:0] age;
    logic                       older;

    // Shared compare: sign match and wrap-around age against the running max
    assign match = rd_valid && (rd_sign == key_sign);
    assign age   = now - rd_time;
    assign older = rd_valid && (age >= old_age_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            hit_idx_reg  <= '0;
            hit_cnt_reg  <= '0;
            free_idx_reg <= '0;
            old_idx_reg  <= '0;
            old_age_reg  <= '0;
        end
        else if (ctrl.init)
        begin
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            old_idx_reg  <= '0;
            old_age_reg  <= '0;
        end
        else if (ctrl.eval)
        begin
            // first live match wins
            if (match && !hit_reg)
            begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= eval_idx;
                hit_cnt_reg <= rd_cnt;
            end
            // first free slot wins
            if (!rd_valid && !free_reg)
            begin
                free_reg     <= 1'b1;
                free_idx_reg <= eval_idx;
            end
            // oldest slot, later index wins a tie
            if (older)
            begin
                old_age_reg <= age;
                old_idx_reg <= eval_idx;
            end
        end
    end

    assign flags.hit  = hit_reg;
    assign flags.free = free_reg;
    assign hit_idx    = hit_idx_reg;
    assign hit_cnt    = hit_cnt_reg;
    assign free_idx   = free_idx_reg;
    assign old_idx    = old_idx_reg;

endmodule

/* hw/rtl/rct_seq.sv */
`timescale 1ns / 1ps

module rct_seq #(
    parameter int SLOTS      = 16,
    parameter int SIGN_BYTES = 5,
    parameter int IDX_W      = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // transaction in
    input  logic                        start,
    output logic                        idle,
    input  logic                        operation,
    input  logic [8*SIGN_BYTES-1:0]     call_sign,
    input  logic [rct_pkg::CNT_W-1:0]   counter,
    input  logic [rct_pkg::TIME_W-1:0]  now_ms,
    // result out
    input  logic                        out_free,
    output logic                        res_valid,
    output logic                        res_accepted,
    output rct_pkg::outcome_t           res_outcome,
    // slot memory
    output logic                        rd_en,
    output logic [IDX_W-1:0]            rd_addr,
    output logic                        wr_en,
    output logic [IDX_W-1:0]            wr_addr,
    output logic [8*SIGN_BYTES-1:0]     wr_sign,
    output logic [rct_pkg::CNT_W-1:0]   wr_cnt,
    output logic [rct_pkg::TIME_W-1:0]  wr_time,
    output logic                        clear_all,
    // scan unit
    output rct_pkg::scan_ctrl_t         scan_ctrl,
    output logic [IDX_W-1:0]            eval_idx,
    output logic [8*SIGN_BYTES-1:0]     key_sign,
    output logic [rct_pkg::TIME_W-1:0]  key_now,
    input  rct_pkg::scan_flags_t        flags,
    input  logic [IDX_W-1:0]            hit_idx,
    input  logic [rct_pkg::CNT_W-1:0]   hit_cnt,
    input  logic [IDX_W-1:0]            free_idx,
    input  logic [IDX_W-1:0]            old_idx
);

    localparam int SIGN_W = 8 * SIGN_BYTES;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_DECIDE
    } state_t;

    state_t                     state_reg, state_next;
    logic [IDX_W-1:0]           scan_idx_reg, scan_idx_next;
    logic                       eval_en_reg, eval_en_next;
    logic [IDX_W-1:0]           eval_idx_reg, eval_idx_next;
    logic                       op_reg, op_next;
    logic                       empty_reg, empty_next;
    logic [SIGN_W-1:0]          sign_reg, sign_next;
    logic [rct_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [rct_pkg::TIME_W-1:0] now_reg, now_next;

    logic [SIGN_W-1:0]          sign_norm;
    logic                       emit;
    logic                       acc;
    rct_pkg::outcome_t          outc;
    logic                       wr_do;
    logic [IDX_W-1:0]           wr_sel;

    // Clear every byte after the first zero byte
    always_comb
    begin
        logic ended;
        ended     = 1'b0;
        sign_norm = '0;
        for (int k = 0; k < SIGN_BYTES; k++)
        begin
            if (call_sign[(SIGN_BYTES-1-k)*8 +: 8] == 8'd0)
            begin
                ended = 1'b1;
            end
            if (!ended)
            begin
                sign_norm[(SIGN_BYTES-1-k)*8 +: 8] = call_sign[(SIGN_BYTES-1-k)*8 +: 8];
            end
        end
    end

    // Final decision from the scan summary
    always_comb
    begin
        acc    = 1'b0;
        outc   = rct_pkg::OUT_CLEARED;
        wr_do  = 1'b0;
        wr_sel = old_idx;
        if (op_reg == rct_pkg::OP_CLEAR)
        begin
            outc = rct_pkg::OUT_CLEARED;
        end
        else if (empty_reg)
        begin
            outc = rct_pkg::OUT_EMPTY;
        end
        else if (flags.hit)
        begin
            if (cnt_reg > hit_cnt)
            begin
                acc    = 1'b1;
                outc   = rct_pkg::OUT_KNOWN;
                wr_do  = 1'b1;
                wr_sel = hit_idx;
            end
            else
            begin
                outc = rct_pkg::OUT_REPLAY;
            end
        end
        else if (flags.free)
        begin
            acc    = 1'b1;
            outc   = rct_pkg::OUT_NEW_FREE;
            wr_do  = 1'b1;
            wr_sel = free_idx;
        end
        else
        begin
            acc    = 1'b1;
            outc   = rct_pkg::OUT_NEW_EVICT;
            wr_do  = 1'b1;
            wr_sel = old_idx;
        end
    end

    // Next-state logic
    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        eval_en_next  = 1'b0;
        eval_idx_next = eval_idx_reg;
        op_next       = op_reg;
        empty_next    = empty_reg;
        sign_next     = sign_reg;
        cnt_next      = cnt_reg;
        now_next      = now_reg;
        emit          = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next       = operation;
                    empty_next    = (sign_norm[SIGN_W-1 -: 8] == 8'd0);
                    sign_next     = sign_norm;
                    cnt_next      = counter;
                    now_next      = now_ms;
                    scan_idx_next = '0;
                    if ((operation == rct_pkg::OP_CLEAR) || (sign_norm[SIGN_W-1 -: 8] == 8'd0))
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                eval_en_next  = 1'b1;
                eval_idx_next = scan_idx_reg;
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            S_LAST:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_idx_reg <= '0;
            eval_en_reg  <= 1'b0;
            eval_idx_reg <= '0;
            op_reg       <= rct_pkg::OP_CHECK;
            empty_reg    <= 1'b0;
            sign_reg     <= '0;
            cnt_reg      <= '0;
            now_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            eval_en_reg  <= eval_en_next;
            eval_idx_reg <= eval_idx_next;
            op_reg       <= op_next;
            empty_reg    <= empty_next;
            sign_reg     <= sign_next;
            cnt_reg      <= cnt_next;
            now_reg      <= now_next;
        end
    end

    assign idle         = (state_reg == S_IDLE);
    assign res_valid    = emit;
    assign res_accepted = acc;
    assign res_outcome  = outc;

    assign rd_en     = (state_reg == S_SCAN);
    assign rd_addr   = scan_idx_reg;
    assign wr_en     = emit && wr_do;
    assign wr_addr   = wr_sel;
    assign wr_sign   = sign_reg;
    assign wr_cnt    = cnt_reg;
    assign wr_time   = now_reg;
    assign clear_all = emit && (op_reg == rct_pkg::OP_CLEAR);

    assign scan_ctrl.init = start && idle;
    assign scan_ctrl.eval = eval_en_reg;
    assign eval_idx       = eval_idx_reg;
    assign key_sign       = sign_reg;
    assign key_now        = now_reg;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int SLOTS      = 16;
    localparam int SIGN_BYTES = 5;
    localparam int SIGN_W     = 8 * SIGN_BYTES;
    localparam int POOL       = 24;    // more senders than slots, so eviction happens
    localparam int MAX_SHOWN  = 10;

    typedef struct {
        logic              accepted;
        rct_pkg::outcome_t outcome;
    } verdict_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        alarm_valid = 1'b0;
    logic                        alarm_ready;
    logic                        operation = rct_pkg::OP_CHECK;
    logic [SIGN_W-1:0]           call_sign = '0;
    logic [rct_pkg::CNT_W-1:0]   counter = '0;
    logic [rct_pkg::TIME_W-1:0]  now_ms = '0;
    logic                        result_valid;
    logic                        result_ready = 1'b0;
    logic                        accepted;
    logic [2:0]                  outcome;

    // Shadow of the sender table
    logic [SIGN_W-1:0]           tbl_sign  [SLOTS];
    logic [rct_pkg::CNT_W-1:0]   tbl_count [SLOTS];
    logic [rct_pkg::TIME_W-1:0]  tbl_heard [SLOTS];

    verdict_t           verdict_q [$];
    int                 err_cnt = 0;
    bit                 steady = 1'b0;    // no gaps on either side while set

    // Stimulus state for the random traffic
    logic [SIGN_W-1:0]           sender_pool [POOL];
    logic [rct_pkg::CNT_W-1:0]   sender_cnt  [POOL];
    logic [rct_pkg::TIME_W-1:0]  clk_ms;

    replay_counter_table #(
        .SLOTS      (SLOTS),
        .SIGN_BYTES (SIGN_BYTES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .alarm_valid  (alarm_valid),
        .alarm_ready  (alarm_ready),
        .operation    (operation),
        .call_sign    (call_sign),
        .counter      (counter),
        .now_ms       (now_ms),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .accepted     (accepted),
        .outcome      (outcome)
    );

    always #10 clk = ~clk;

    // Run limit, far above the slowest legal run
    initial
    begin
        #10_000_000;
        $display("tb: done, errors");
        $finish;
    end

    function automatic logic [SIGN_W-1:0] rand_sign();
        logic [7:0]  hi;
        logic [31:0] lo;
        hi = 8'($urandom_range(0, 255));
        lo = $urandom();
        return {hi, lo};
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Bytes after the first zero byte do not count
    function automatic logic [SIGN_W-1:0] trim_sign(input logic [SIGN_W-1:0] s);
        logic [SIGN_W-1:0] r;
        bit                ended;
        r = '0;
        ended = 1'b0;
        for (int k = SIGN_BYTES - 1; k >= 0; k--)
        begin
            if (s[8*k +: 8] == 8'h00)
                ended = 1'b1;
            if (!ended)
                r[8*k +: 8] = s[8*k +: 8];
        end
        return r;
    endfunction

    // Fill the bytes after the first zero byte with junk
    function automatic logic [SIGN_W-1:0] smudge_tail(input logic [SIGN_W-1:0] s);
        logic [SIGN_W-1:0] r;
        bit                ended;
        r = s;
        ended = 1'b0;
        for (int k = SIGN_BYTES - 1; k >= 0; k--)
        begin
            if (ended)
                r[8*k +: 8] = 8'($urandom_range(0, 255));
            if (s[8*k +: 8] == 8'h00)
                ended = 1'b1;
        end
        return r;
    endfunction

    task automatic flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_SHOWN)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Apply one alarm to the shadow table and queue the verdict it earns
    task automatic predict_alarm(input logic op, input logic [SIGN_W-1:0] raw,
                                 input logic [rct_pkg::CNT_W-1:0] cnt,
                                 input logic [rct_pkg::TIME_W-1:0] stamp);
        logic [SIGN_W-1:0]          s;
        logic [rct_pkg::TIME_W-1:0] age;
        logic [rct_pkg::TIME_W-1:0] oldest;
        int                         hit;
        int                         victim;
        int                         free_idx;
        verdict_t                   v;
        s = trim_sign(raw);
        v.accepted = 1'b0;
        if (op == rct_pkg::OP_CLEAR)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                tbl_sign[i]  = '0;
                tbl_count[i] = '0;
                tbl_heard[i] = '0;
            end
            v.outcome = rct_pkg::OUT_CLEARED;
        end
        else if (s[SIGN_W-1 -: 8] == 8'h00)
        begin
            v.outcome = rct_pkg::OUT_EMPTY;
        end
        else
        begin
            hit = -1;
            for (int i = 0; i < SLOTS; i++)
                if (hit < 0 && tbl_sign[i][SIGN_W-1 -: 8] != 8'h00 && tbl_sign[i] == s)
                    hit = i;
            if (hit >= 0)
            begin
                if (cnt <= tbl_count[hit])
                    v.outcome = rct_pkg::OUT_REPLAY;
                else
                begin
                    tbl_count[hit] = cnt;
                    tbl_heard[hit] = stamp;
                    v.accepted = 1'b1;
                    v.outcome = rct_pkg::OUT_KNOWN;
                end
            end
            else
            begin
                // first free slot, else the oldest one (later index on a tie)
                victim = 0;
                oldest = '0;
                free_idx = -1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (free_idx < 0)
                    begin
                        if (tbl_sign[i][SIGN_W-1 -: 8] == 8'h00)
                            free_idx = i;
                        else
                        begin
                            age = stamp - tbl_heard[i];
                            if (age >= oldest)
                            begin
                                oldest = age;
                                victim = i;
                            end
                        end
                    end
                end
                if (free_idx >= 0)
                begin
                    victim = free_idx;
                    v.outcome = rct_pkg::OUT_NEW_FREE;
                end
                else
                    v.outcome = rct_pkg::OUT_NEW_EVICT;
                tbl_sign[victim]  = s;
                tbl_count[victim] = cnt;
                tbl_heard[victim] = stamp;
                v.accepted = 1'b1;
            end
        end
        verdict_q.push_back(v);
    endtask

    // One alarm transaction; called and returns at a rising edge
    task automatic send_alarm(input logic op, input logic [SIGN_W-1:0] sign,
                              input logic [rct_pkg::CNT_W-1:0] cnt,
                              input logic [rct_pkg::TIME_W-1:0] stamp);
        int gap;
        alarm_valid <= 1'b1;
        operation   <= op;
        call_sign   <= sign;
        counter     <= cnt;
        now_ms      <= stamp;
        do
            @(posedge clk);
        while (!alarm_ready);
        predict_alarm(op, sign, cnt, stamp);
        gap = 0;
        if (!steady && $urandom_range(0, 2) == 0)
            gap = pick_gap();
        if (gap > 0)
        begin
            alarm_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Result side: random stalls
    initial
    begin : result_sink
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (stall > 0 && !steady)
            begin
                result_ready <= 1'b0;
                stall--;
            end
            else
            begin
                result_ready <= 1'b1;
                stall = 0;
                if (!steady && $urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    // Compare every result transaction with the oldest pending verdict
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (verdict_q.size() == 0)
                flag_error($sformatf("result acc=%0d out=%0d with nothing pending",
                                     accepted, outcome));
            else
            begin
                want = verdict_q.pop_front();
                if (accepted !== want.accepted)
                    flag_error($sformatf("accepted exp %0d got %0d",
                                         want.accepted, accepted));
                if (outcome !== want.outcome)
                    flag_error($sformatf("outcome exp %0d got %0d",
                                         want.outcome, outcome));
            end
        end
    end

    // Empty signs, junk after a zero byte, replays, extreme counters
    task automatic test_reject_and_refresh();
        send_alarm(rct_pkg::OP_CHECK, {8'h00, 32'hDEAD_BEEF}, 32'd7, 32'd10);
        send_alarm(rct_pkg::OP_CHECK, {8'h4B, 8'h00, 24'hAB_CDEF}, 32'd5, 32'd11);
        send_alarm(rct_pkg::OP_CHECK, {8'h4B, 8'h00, 24'h12_3456}, 32'd6, 32'd12);
        send_alarm(rct_pkg::OP_CHECK, {8'h4B, 8'h00, 24'h00_0000}, 32'd6, 32'd13);
        send_alarm(rct_pkg::OP_CHECK, {8'h4B, 8'h00, 24'hFF_FFFF}, 32'hFFFF_FFFF, 32'd14);
        send_alarm(rct_pkg::OP_CHECK, {SIGN_W{1'b1}}, 32'd0, 32'hFFFF_FFFF);
        send_alarm(rct_pkg::OP_CHECK, {SIGN_W{1'b1}}, 32'd0, 32'd0);
    endtask

    // Fill every slot, then evict on an age tie and on a wrapped age
    task automatic test_fill_and_evict();
        send_alarm(rct_pkg::OP_CLEAR, rand_sign(), $urandom(), $urandom());
        for (int i = 0; i < SLOTS; i++)
            send_alarm(rct_pkg::OP_CHECK, {8'h41 + 8'(i), 32'h5A5A_0000 + 32'(i)},
                       32'(i), 32'd100);
        // all ages equal: the last slot goes
        send_alarm(rct_pkg::OP_CHECK, {8'h58, 32'h0102_0304}, 32'd1, 32'd100);
        // refresh slot 3 in the future; next time its age wraps to the largest
        send_alarm(rct_pkg::OP_CHECK, {8'h44, 32'h5A5A_0003}, 32'd100, 32'd200);
        send_alarm(rct_pkg::OP_CHECK, {8'h59, 32'h0506_0708}, 32'd1, 32'd150);
    endtask

    // One random alarm, mostly from the known sender pool
    task automatic random_alarm();
        int                        r;
        int                        idx;
        logic [SIGN_W-1:0]         s;
        logic [rct_pkg::CNT_W-1:0] c;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0)
            clk_ms = $urandom();
        else
            clk_ms = clk_ms + $urandom_range(0, 300);
        if (r < 2)
            send_alarm(rct_pkg::OP_CLEAR, rand_sign(), $urandom(), $urandom());
        else if (r < 6)
            send_alarm(rct_pkg::OP_CHECK, {8'h00, 32'($urandom())}, $urandom(), clk_ms);
        else if (r < 12)
            send_alarm(rct_pkg::OP_CHECK, rand_sign(), $urandom(), clk_ms);
        else
        begin
            idx = $urandom_range(0, POOL - 1);
            s = sender_pool[idx];
            if ($urandom_range(0, 1) == 1)
                s = smudge_tail(s);
            r = $urandom_range(0, 9);
            if (r < 7)
                c = sender_cnt[idx] + $urandom_range(1, 500);
            else if (r < 9)
                c = sender_cnt[idx] - $urandom_range(0, 3);
            else
                c = $urandom();
            sender_cnt[idx] = c;
            send_alarm(rct_pkg::OP_CHECK, s, c, clk_ms);
        end
    endtask

    task automatic test_random_traffic(input int n_items);
        logic [7:0] b;
        clk_ms = 32'hFFFF_0000;
        for (int i = 0; i < POOL; i++)
        begin
            b = 8'($urandom_range(1, 255));
            sender_pool[i] = {b, 32'($urandom())};
            // some call signs are shorter than the field
            if ($urandom_range(0, 2) == 0)
                sender_pool[i][8*$urandom_range(0, SIGN_BYTES - 2) +: 8] = 8'h00;
            sender_cnt[i] = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 : $urandom_range(0, 1000);
        end
        for (int i = 0; i < n_items; i++)
            random_alarm();
    endtask

    // Both sides at full rate
    task automatic test_back_to_back(input int n_items);
        steady = 1'b1;
        for (int i = 0; i < n_items; i++)
            random_alarm();
        steady = 1'b0;
    endtask

    initial
    begin
        int wait_cyc;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_sign[i]  = '0;
            tbl_count[i] = '0;
            tbl_heard[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_reject_and_refresh();
        test_fill_and_evict();
        test_random_traffic(575);
        test_back_to_back(50);

        alarm_valid <= 1'b0;
        wait_cyc = 0;
        while (verdict_q.size() != 0 && wait_cyc < 5000)
        begin
            @(posedge clk);
            wait_cyc++;
        end
        if (verdict_q.size() != 0)
            flag_error($sformatf("%0d results never arrived", verdict_q.size()));
        repeat (SLOTS + 8) @(posedge clk);

        if (err_cnt == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
